[rtl/led_pulse_blink_controller_core_macros.svh]
// Assertion macros for the LED pulse/blink controller.
// Used by the top level; no other dependencies.
`ifndef LED_PULSE_BLINK_CONTROLLER_CORE_MACROS_SVH
`define LED_PULSE_BLINK_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lpbc_pkg.sv]
// Shared types and codes for the LED pulse/blink controller.
// No dependencies.
package lpbc_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_PULSE     = 3'd1;
    localparam logic [2:0] CMD_BLINK     = 3'd2;
    localparam logic [2:0] CMD_SET       = 3'd3;
    localparam logic [2:0] CMD_BLINK_OFF = 3'd4;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_FIXED = 2'd1;
    localparam logic [1:0] MODE_PULSE = 2'd2;
    localparam logic [1:0] MODE_BLINK = 2'd3;

    localparam logic [0:0] REG_ON_LEVEL = 1'b0;

    typedef struct packed {
        logic [2:0]        command;
        logic [31:0]       first_time;
        logic [31:0]       second_time;
        logic signed [7:0] blink_count;
        logic              fixed_level;
    } item_t;

    typedef struct packed {
        logic       pin_level;
        logic       logical_on;
        logic [1:0] mode;
    } result_t;

endpackage

[rtl/lpbc_engine.sv]
// Mode state and per-command update of the LED pulse/blink controller.
// Depends on lpbc_pkg.
module lpbc_engine
    import lpbc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  item_t   item,
    input  logic    on_level,
    output result_t result
);

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [1:0]           mode_reg, mode_next;
    logic                 counted_reg, counted_next;
    logic                 led_on_reg, led_on_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0] on_ticks_reg, on_ticks_next;
    logic [TIME_BITS-1:0] off_ticks_reg, off_ticks_next;
    logic [7:0]           cycles_reg, cycles_next;

    logic [TIME_BITS+31:0] t1_wide, t2_wide;
    logic [TIME_BITS-1:0]  t1, t2;
    logic [TIME_BITS-1:0]  el_inc;
    logic [7:0]            cyc_dec;
    logic                  cnt_pos;

    assign t1_wide = {{TIME_BITS{1'b0}}, item.first_time};
    assign t2_wide = {{TIME_BITS{1'b0}}, item.second_time};
    assign t1      = t1_wide[TIME_BITS-1:0];
    assign t2      = t2_wide[TIME_BITS-1:0];
    assign el_inc  = (elapsed_reg != TIME_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign cyc_dec = cycles_reg - 8'd1;
    assign cnt_pos = (item.blink_count != 8'sd0) && !item.blink_count[7];

    always_comb
    begin
        mode_next      = mode_reg;
        counted_next   = counted_reg;
        led_on_next    = led_on_reg;
        elapsed_next   = elapsed_reg;
        on_ticks_next  = on_ticks_reg;
        off_ticks_next = off_ticks_reg;
        cycles_next    = cycles_reg;
        unique case (item.command)
            CMD_TICK:
            begin
                elapsed_next = el_inc;
                if (mode_reg == MODE_PULSE)
                begin
                    if (el_inc >= on_ticks_reg)
                    begin
                        mode_next    = MODE_IDLE;
                        counted_next = 1'b0;
                        led_on_next  = 1'b0;
                    end
                end
                else if (mode_reg == MODE_BLINK)
                begin
                    if (led_on_reg)
                    begin
                        if (el_inc >= on_ticks_reg)
                        begin
                            led_on_next  = 1'b0;
                            elapsed_next = '0;
                        end
                    end
                    else if (el_inc >= off_ticks_reg)
                    begin
                        led_on_next  = 1'b1;
                        elapsed_next = '0;
                        if (counted_reg)
                        begin
                            cycles_next = cyc_dec;
                            if (cyc_dec == 8'd0 || cyc_dec[7])
                            begin
                                mode_next    = MODE_IDLE;
                                counted_next = 1'b0;
                                led_on_next  = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_PULSE:
            begin
                if (mode_reg != MODE_PULSE)
                begin
                    mode_next     = MODE_PULSE;
                    counted_next  = 1'b0;
                    cycles_next   = 8'd0;
                    on_ticks_next = t1;
                    elapsed_next  = '0;
                    led_on_next   = 1'b1;
                end
            end
            CMD_BLINK:
            begin
                if (mode_reg != MODE_BLINK)
                begin
                    mode_next      = MODE_BLINK;
                    counted_next   = cnt_pos;
                    if (cnt_pos)
                        cycles_next = item.blink_count;
                    on_ticks_next  = t1;
                    off_ticks_next = t2;
                    elapsed_next   = '0;
                    led_on_next    = 1'b1;
                end
            end
            CMD_SET:
            begin
                mode_next    = MODE_FIXED;
                counted_next = 1'b0;
                cycles_next  = 8'd0;
                led_on_next  = item.fixed_level;
            end
            CMD_BLINK_OFF:
            begin
                if (mode_reg == MODE_BLINK)
                begin
                    mode_next    = MODE_FIXED;
                    counted_next = 1'b0;
                    cycles_next  = 8'd0;
                    led_on_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            counted_reg   <= 1'b0;
            led_on_reg    <= 1'b0;
            elapsed_reg   <= '0;
            on_ticks_reg  <= '0;
            off_ticks_reg <= '0;
            cycles_reg    <= 8'd0;
        end
        else if (en)
        begin
            mode_reg      <= mode_next;
            counted_reg   <= counted_next;
            led_on_reg    <= led_on_next;
            elapsed_reg   <= elapsed_next;
            on_ticks_reg  <= on_ticks_next;
            off_ticks_reg <= off_ticks_next;
            cycles_reg    <= cycles_next;
        end
    end

    assign result.pin_level  = led_on_next ? on_level : !on_level;
    assign result.logical_on = led_on_next;
    assign result.mode       = mode_next;

endmodule

[rtl/led_pulse_blink_controller_core.sv]
// LED pulse/blink controller: one command in, one pin status out. Each transfer
// on the slave stream is latched into an input register; once the output side
// can take a result, the mode engine applies it and the status is loaded
// into the output register. One command is taken every clock as long as the
// master side keeps up; the rate is set by the single state update in
// lpbc_engine. The on-level register (APB address 0x0) selects whether logical
// on drives the pin high or low.
// Depends on lpbc_pkg, lpbc_engine and led_pulse_blink_controller_core_macros.svh.
`include "led_pulse_blink_controller_core_macros.svh"

module led_pulse_blink_controller_core
    import lpbc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // first_time[31:0], second_time[63:32],
                                  // blink_count[71:64], fixed_level[72], zero pad
    input  logic [2:0]  s_tuser,  // command[2:0]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // pin_level[0], logical_on[1], mode[3:2], zero pad
);

    logic    on_level_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result_reg;
    logic    out_valid_reg;
    result_t eng_result;
    logic    advance;
    logic    s_xfer;
    logic    cfg_wr;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_ON_LEVEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            on_level_reg <= 1'b1;
        else if (cfg_wr)
            on_level_reg <= pwdata[0];
    end

    assign prdata = (paddr[2:2] == REG_ON_LEVEL) ? {31'd0, on_level_reg} : 32'd0;

    // input register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_xfer)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            item_reg.command     <= s_tuser;
            item_reg.first_time  <= s_tdata[31:0];
            item_reg.second_time <= s_tdata[63:32];
            item_reg.blink_count <= s_tdata[71:64];
            item_reg.fixed_level <= s_tdata[72];
        end
    end

    lpbc_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .item     (item_reg),
        .on_level (on_level_reg),
        .result   (eng_result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= eng_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, result_reg.mode, result_reg.logical_on, result_reg.pin_level};

    `LPBC_ASSERT_NEXT(a_accept_fills, clk, rst_n, s_xfer, in_valid_reg, "accepted transfer lost")
    `LPBC_ASSERT_NEXT(a_advance_out, clk, rst_n, advance, out_valid_reg, "result not registered")
    `LPBC_ASSERT_NEXT(a_stall_hold, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(item_reg), "stalled command changed")
    `LPBC_ASSERT_NOW(a_idle_off, clk, rst_n, out_valid_reg && result_reg.mode == MODE_IDLE,
        !result_reg.logical_on, "idle mode reports on")
    `LPBC_ASSERT_NOW(a_pulse_on, clk, rst_n, out_valid_reg && result_reg.mode == MODE_PULSE,
        result_reg.logical_on, "pulse mode reports off")

endmodule
